### src/sdds_pkg.sv
// Shared constants, types and the quarter-wave sine table builder for the
// stereo oscillator mixer. No dependencies.
package sdds_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 24;

    localparam int AUDIO_BITS    = 24;
    localparam int GAIN_BITS     = 16;
    localparam int PHASE_BITS    = 32;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 32;
    localparam int WAVE_BITS     = 2;

    localparam int SINE_TBL_LEN  = (1 << SINE_TABLE_BITS) + 1;
    localparam int SINE_POS_BITS = SINE_TABLE_BITS + 1;
    localparam int AMP_BITS      = SAMPLE_BITS - 1;
    localparam int PROD_BITS     = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int CONTRIB_SHIFT = SAMPLE_BITS - 9;
    localparam int CONTRIB_BITS  = PROD_BITS - CONTRIB_SHIFT;
    localparam int SUM_BITS      = CONTRIB_BITS + 1;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_WAVEFORM   = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_INC  = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_PHASE = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN       = 8'd3;

    // waveform codes
    localparam logic [WAVE_BITS-1:0] WAVE_SINE   = 2'd0;
    localparam logic [WAVE_BITS-1:0] WAVE_SQUARE = 2'd1;
    localparam logic [WAVE_BITS-1:0] WAVE_SAW    = 2'd2;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned FULL_AMP    = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    typedef logic [AMP_BITS-1:0] sine_rom_t [SINE_TBL_LEN];

    function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // Taylor series in Q30, Horner form through x^15, evaluated at elaboration
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t       rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned r;
        longint unsigned p;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        for (int k = 0; k < SINE_TBL_LEN; k++) begin
            x  = (longint'(k) * HALF_PI_Q30 + (64'd1 << (SINE_TABLE_BITS - 1)))
                 >> SINE_TABLE_BITS;
            x2 = mul_q30(x, x);
            r  = Q30_ONE;
            for (int n = 14; n >= 2; n -= 2) begin
                p = mul_q30(x2, r);
                unique case (n)
                    14: t = p / 64'd210;
                    12: t = p / 64'd156;
                    10: t = p / 64'd110;
                    8:  t = p / 64'd72;
                    6:  t = p / 64'd42;
                    4:  t = p / 64'd20;
                    2:  t = p / 64'd6;
                    default: t = 64'd0;
                endcase
                r = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
            end
            s = mul_q30(x, r);
            if (s > Q30_ONE) s = Q30_ONE;
            v = (s * FULL_AMP + (64'd1 << 29)) >> 30;
            if (v > FULL_AMP) v = FULL_AMP;
            rom[k] = v[AMP_BITS-1:0];
        end
        return rom;
    endfunction

endpackage

### src/stereo_dds_oscillator_mixer.sv
// Stereo DDS oscillator mixer: phase accumulator, quarter-wave sine ROM,
// gain multiply and saturating mix into both channels. Depends on sdds_pkg.

// One frame per clock is accepted and one result frame leaves per clock unless the
// output stalls. A frame passes the registered stages in order: the sine ROM is
// read with a registered output as the frame is taken, the selected waveform
// sample is multiplied by the gain in the second stage, and the saturating add to
// left and right fills the output register. The phase accumulator advances by
// phase_increment with every accepted frame; writing start_phase reloads it.
// Backpressure on the result side ripples back stage by stage, so the input keeps
// taking frames while bubbles remain. Configuration writes are always taken and
// should be made only when the block is idle; unknown register indexes are ignored.
module stereo_dds_oscillator_mixer
    import sdds_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // config write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    // input frames
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [2*AUDIO_BITS-1:0]  s_tdata,   // left_in [23:0], right_in [47:24]
    input  logic                     s_tlast,   // end_of_block
    // result frames
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [2*AUDIO_BITS-1:0]  m_tdata,   // left_out [23:0], right_out [47:24]
    output logic                     m_tlast    // block_last
);

    localparam logic signed [SUM_BITS-1:0] OUT_MAX =
        SUM_BITS'((64'd1 << (AUDIO_BITS - 1)) - 64'd1);
    localparam logic signed [SUM_BITS-1:0] OUT_MIN = -OUT_MAX - SUM_BITS'(1);
    localparam logic signed [SAMPLE_BITS-1:0] AMP_POS = SAMPLE_BITS'(FULL_AMP);
    localparam logic signed [PROD_BITS-1:0] ROUND_BIAS =
        PROD_BITS'(64'd1 << (SAMPLE_BITS - 10));
    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // configuration
    logic [WAVE_BITS-1:0]  waveform_reg;
    logic [PHASE_BITS-1:0] phase_inc_reg;
    logic [GAIN_BITS-1:0]  gain_reg;
    logic [PHASE_BITS-1:0] phase_accum_reg;
    logic [PHASE_BITS-1:0] phase_accum_next;

    // stage 1: ROM output and frame; only the top phase bits are kept
    logic                    st1_valid_reg;
    logic [AUDIO_BITS-1:0]   st1_left_reg;
    logic [AUDIO_BITS-1:0]   st1_right_reg;
    logic                    st1_last_reg;
    logic [SAMPLE_BITS-1:0]  st1_phase_reg;
    logic [AMP_BITS-1:0]     rom_q_reg;

    // stage 2: scaled contribution
    logic                           st2_valid_reg;
    logic [AUDIO_BITS-1:0]          st2_left_reg;
    logic [AUDIO_BITS-1:0]          st2_right_reg;
    logic                           st2_last_reg;
    logic signed [CONTRIB_BITS-1:0] st2_contrib_reg;

    // output register
    logic                  m_valid_reg;
    logic [AUDIO_BITS-1:0] m_left_reg;
    logic [AUDIO_BITS-1:0] m_right_reg;
    logic                  m_last_reg;

    logic en_out;
    logic en_st2;
    logic en_st1;
    logic s_accept;
    logic cfg_write;

    logic                        quad_odd;
    logic [SINE_TABLE_BITS-1:0]  idx;
    logic [SINE_POS_BITS-1:0]    rom_pos;

    logic signed [SAMPLE_BITS-1:0]  sine_smp;
    logic signed [SAMPLE_BITS-1:0]  sample;
    logic signed [PROD_BITS-1:0]    product;
    logic signed [PROD_BITS-1:0]    prod_rnd;
    logic signed [CONTRIB_BITS-1:0] contrib_next;

    logic signed [SUM_BITS-1:0] left_sum;
    logic signed [SUM_BITS-1:0] right_sum;
    logic [AUDIO_BITS-1:0]      left_next;
    logic [AUDIO_BITS-1:0]      right_next;

    // per-stage advance: a stage moves when the one after it is empty or moving
    assign en_out    = !m_valid_reg || m_tready;
    assign en_st2    = !st2_valid_reg || en_out;
    assign en_st1    = !st1_valid_reg || en_st2;
    assign s_tready  = en_st1;
    assign s_accept  = s_tvalid && en_st1;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // ---------------- configuration and phase ----------------
    always_comb begin
        phase_accum_next = phase_accum_reg;
        if (cfg_write && cfg_index == REG_START_PHASE) begin
            phase_accum_next = cfg_data[PHASE_BITS-1:0];
        end else if (s_accept) begin
            phase_accum_next = phase_accum_reg + phase_inc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waveform_reg    <= WAVE_SINE;
            phase_inc_reg   <= '0;
            gain_reg        <= '0;
            phase_accum_reg <= '0;
        end else begin
            phase_accum_reg <= phase_accum_next;
            if (cfg_write) begin
                unique case (cfg_index)
                    REG_WAVEFORM:  waveform_reg  <= cfg_data[WAVE_BITS-1:0];
                    REG_PHASE_INC: phase_inc_reg <= cfg_data[PHASE_BITS-1:0];
                    REG_GAIN:      gain_reg      <= cfg_data[GAIN_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ---------------- stage 1: ROM read ----------------
    assign quad_odd = phase_accum_reg[PHASE_BITS-2];
    assign idx      = phase_accum_reg[PHASE_BITS-3 -: SINE_TABLE_BITS];
    assign rom_pos  = quad_odd ? (SINE_POS_BITS'(1) << SINE_TABLE_BITS) - {1'b0, idx}
                               : {1'b0, idx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (en_st1) begin
            st1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_left_reg  <= s_tdata[AUDIO_BITS-1:0];
            st1_right_reg <= s_tdata[2*AUDIO_BITS-1:AUDIO_BITS];
            st1_last_reg  <= s_tlast;
            st1_phase_reg <= phase_accum_reg[PHASE_BITS-1 -: SAMPLE_BITS];
            rom_q_reg     <= SINE_ROM[rom_pos];
        end
    end

    // ---------------- stage 2: waveform select and gain ----------------
    assign sine_smp = st1_phase_reg[SAMPLE_BITS-1] ? -$signed({1'b0, rom_q_reg})
                                                   :  $signed({1'b0, rom_q_reg});

    always_comb begin
        unique case (waveform_reg)
            WAVE_SINE:   sample = sine_smp;
            WAVE_SQUARE: sample = st1_phase_reg[SAMPLE_BITS-1] ? -AMP_POS : AMP_POS;
            // phase scaled to -1..+1: offset binary to two's complement
            WAVE_SAW:    sample = $signed({~st1_phase_reg[SAMPLE_BITS-1],
                                  st1_phase_reg[SAMPLE_BITS-2:0]});
            default:     sample = '0;
        endcase
    end

    assign product      = PROD_BITS'(sample) * $signed({1'b0, gain_reg});
    assign prod_rnd     = product + ROUND_BIAS;
    assign contrib_next = CONTRIB_BITS'(prod_rnd >>> CONTRIB_SHIFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else if (en_st2) begin
            st2_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_st2 && st1_valid_reg) begin
            st2_left_reg    <= st1_left_reg;
            st2_right_reg   <= st1_right_reg;
            st2_last_reg    <= st1_last_reg;
            st2_contrib_reg <= contrib_next;
        end
    end

    // ---------------- stage 3: saturating mix ----------------
    assign left_sum  = SUM_BITS'($signed(st2_left_reg)) + SUM_BITS'(st2_contrib_reg);
    assign right_sum = SUM_BITS'($signed(st2_right_reg)) + SUM_BITS'(st2_contrib_reg);

    always_comb begin
        priority if (left_sum > OUT_MAX) begin
            left_next = OUT_MAX[AUDIO_BITS-1:0];
        end else if (left_sum < OUT_MIN) begin
            left_next = OUT_MIN[AUDIO_BITS-1:0];
        end else begin
            left_next = left_sum[AUDIO_BITS-1:0];
        end
        priority if (right_sum > OUT_MAX) begin
            right_next = OUT_MAX[AUDIO_BITS-1:0];
        end else if (right_sum < OUT_MIN) begin
            right_next = OUT_MIN[AUDIO_BITS-1:0];
        end else begin
            right_next = right_sum[AUDIO_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en_out) begin
            m_valid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out && st2_valid_reg) begin
            m_left_reg  <= left_next;
            m_right_reg <= right_next;
            m_last_reg  <= st2_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_right_reg, m_left_reg};
    assign m_tlast  = m_last_reg;

    // ---------------- assertions ----------------
    a_start_phase_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_write && cfg_index == REG_START_PHASE
        |=> phase_accum_reg == $past(cfg_data[PHASE_BITS-1:0]))
        else $error("start_phase write did not load the accumulator");

    a_phase_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !(cfg_write && cfg_index == REG_START_PHASE)
        |=> phase_accum_reg == $past(phase_accum_reg + phase_inc_reg))
        else $error("phase did not advance on accepted request");

    a_phase_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept && !(cfg_write && cfg_index == REG_START_PHASE)
        |=> $stable(phase_accum_reg))
        else $error("phase moved without a request");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready && st2_valid_reg && st1_valid_reg |-> !s_tready)
        else $error("input taken while pipeline is full and stalled");

    a_out_from_st2: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(st2_valid_reg))
        else $error("result appeared without a frame in stage 2");

endmodule
